@@ rtl/ctfq_pkg.sv @@
// ----------------------------------------------------------------------------
// ctfq_pkg
// Types, codes and helpers shared by the CAN transmit frame queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ctfq_pkg;

  localparam logic [1:0]  OP_PUSH_STD = 2'd0;
  localparam logic [1:0]  OP_PUSH_EXT = 2'd1;
  localparam logic [1:0]  OP_TICK     = 2'd2;

  localparam logic [3:0]  MAX_LEN     = 4'd8;
  localparam logic [15:0] OVF_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [28:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
    logic        tx_buffer_free;
    logic        tx_complete;
    logic        bus_off;
  } in_item_t;

  typedef struct packed {
    logic        push_accepted;
    logic [15:0] overflow_count;
    logic [4:0]  queue_count;
    logic        send_valid;
    logic [28:0] send_id;
    logic        send_extended;
    logic [3:0]  send_length;
    logic [63:0] send_data;
    logic        send_refused;
    logic        waiting;
    logic        reinit_request;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_PUSH,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    logic        ext;
    logic [3:0]  len;
    logic [28:0] id;
    logic [63:0] data;
  } entry_t;

  typedef struct packed {
    cmd_kind_t   kind;
    entry_t      frame;
    logic        buf_free;
    logic        done;
    logic        boff;
  } cmd_t;

  typedef enum logic {
    BK_EXEC,
    BK_SEND
  } back_state_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] mask;
    mask = '0;
    for (int i = 0; i < 8; i++) begin
      mask[i*8 +: 8] = (4'(i) < len) ? 8'hFF : 8'h00;
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

@@ rtl/can_tx_frame_queue_top.sv @@
// ----------------------------------------------------------------------------
// can_tx_frame_queue_top
// Transmit frame queue for a CAN controller with a send sequencer.
// ----------------------------------------------------------------------------
// push, idle tick, unknown op: command queue, then result register; a tick
//   that pops a frame adds the registered ring read and the send state
// throughput: one item per cycle unless out_stall or a popping tick (BK_SEND)
// reset: pointers, wait flag and overflow counter cleared,
//   ring contents are not cleared
`default_nettype none

module can_tx_frame_queue_top
  import ctfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  logic cmd_in_valid;
  logic cmd_in_stall;
  cmd_t cmd_in;
  logic cmd_out_valid;
  logic cmd_out_take;
  cmd_t cmd_out;

  ctfq_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_in_valid),
    .cmd_stall (cmd_in_stall),
    .cmd       (cmd_in)
  );

  ctfq_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cmd_in_valid),
    .wr_stall (cmd_in_stall),
    .wr_data  (cmd_in),
    .rd_valid (cmd_out_valid),
    .rd_take  (cmd_out_take),
    .rd_data  (cmd_out)
  );

  ctfq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_out_valid),
    .cmd       (cmd_out),
    .cmd_take  (cmd_out_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/ctfq_ram.sv @@
// ----------------------------------------------------------------------------
// ctfq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ctfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/ctfq_front.sv @@
// ----------------------------------------------------------------------------
// ctfq_front
// Accepts input items, decodes the op and prepares the frame fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ctfq_front
  import ctfq_pkg::*;
(
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          cmd_valid,
  input  wire logic     cmd_stall,
  output cmd_t          cmd
);

  logic [3:0] len_clamped;
  logic       ext;

  assign in_stall    = cmd_stall;
  assign cmd_valid   = in_valid;
  assign len_clamped = (in_data.frame_length > MAX_LEN) ? MAX_LEN : in_data.frame_length;
  assign ext         = (in_data.op == OP_PUSH_EXT);

  always_comb begin
    unique case (in_data.op) inside
      OP_PUSH_STD, OP_PUSH_EXT: cmd.kind = CMD_PUSH;
      OP_TICK:                  cmd.kind = CMD_TICK;
      default:                  cmd.kind = CMD_NOP;
    endcase
  end

  always_comb begin
    cmd.frame.ext  = ext;
    cmd.frame.len  = len_clamped;
    cmd.frame.id   = ext ? in_data.frame_id : {18'd0, in_data.frame_id[10:0]};
    cmd.frame.data = in_data.frame_data & byte_mask(len_clamped);
    cmd.buf_free   = in_data.tx_buffer_free;
    cmd.done       = in_data.tx_complete;
    cmd.boff       = in_data.bus_off;
  end

endmodule

`default_nettype wire

@@ rtl/ctfq_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// ctfq_cmd_fifo
// Two-entry command queue between the front and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ctfq_cmd_fifo
  import ctfq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_stall,
  input  wire cmd_t wr_data,
  output logic      rd_valid,
  input  wire logic rd_take,
  output cmd_t      rd_data
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && !wr_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(rd_take);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ctfq_back.sv @@
// ----------------------------------------------------------------------------
// ctfq_back
// Frame ring, send sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctfq_back
  import ctfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_take,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int PW = IW + 1;

  back_state_t state, state_next;
  logic [PW-1:0] wp, wp_next;
  logic [PW-1:0] rp, rp_next;
  logic          wait_flag, wait_flag_next;
  logic [15:0]   ovf, ovf_next;
  logic          send_free;
  logic          send_reinit;
  logic          pop_load;

  logic [PW-1:0] fill;
  logic [PW-1:0] fill_next;
  logic [31:0]   fill_wide;
  logic          full;
  logic          empty;
  logic          out_free;

  logic          ram_we;
  logic          ram_re;
  entry_t        ram_rdata;

  logic          res_load;
  out_item_t     res;

  assign fill      = wp - rp;
  assign full      = fill[PW-1];
  assign empty     = (wp == rp);
  assign out_free  = !out_valid || !out_stall;
  assign fill_next = wp_next - rp_next;
  assign fill_wide = 32'(fill_next);

  ctfq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp[IW-1:0]),
    .wdata (cmd.frame),
    .re    (ram_re),
    .raddr (rp[IW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_EXEC;
      wp        <= '0;
      rp        <= '0;
      wait_flag <= 1'b0;
      ovf       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wp        <= wp_next;
      rp        <= rp_next;
      wait_flag <= wait_flag_next;
      ovf       <= ovf_next;
      out_valid <= res_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= res;
    end
    if (pop_load) begin
      send_free   <= cmd.buf_free;
      send_reinit <= cmd.boff;
    end
  end

  always_comb begin
    state_next     = state;
    wp_next        = wp;
    rp_next        = rp;
    wait_flag_next = wait_flag;
    ovf_next       = ovf;
    cmd_take       = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    pop_load       = 1'b0;
    res_load       = 1'b0;
    res            = '0;

    unique case (state)
      BK_EXEC: begin
        if (cmd_valid && out_free) begin
          cmd_take = 1'b1;
          res_load = 1'b1;
          case (cmd.kind)
            CMD_PUSH: begin
              if (full) begin
                if (ovf != OVF_MAX) begin
                  ovf_next = ovf + 16'd1;
                end
                rp_next = wp;
              end else begin
                ram_we            = 1'b1;
                wp_next           = wp + PW'(1);
                res.push_accepted = 1'b1;
              end
            end
            CMD_TICK: begin
              if (!wait_flag) begin
                if (!empty) begin
                  ram_re         = 1'b1;
                  pop_load       = 1'b1;
                  rp_next        = rp + PW'(1);
                  wait_flag_next = 1'b1;
                  state_next     = BK_SEND;
                  res_load       = 1'b0;
                end
              end else if (cmd.done) begin
                wait_flag_next = 1'b0;
              end
              res.reinit_request = cmd.boff;
            end
            default: begin
            end
          endcase
        end
      end
      BK_SEND: begin
        if (out_free) begin
          res_load           = 1'b1;
          state_next         = BK_EXEC;
          res.send_valid     = send_free;
          res.send_refused   = !send_free;
          res.reinit_request = send_reinit;
          if (send_free) begin
            res.send_id       = ram_rdata.id;
            res.send_extended = ram_rdata.ext;
            res.send_length   = ram_rdata.len;
            res.send_data     = ram_rdata.data;
          end
        end
      end
      default: begin
        state_next = BK_EXEC;
      end
    endcase

    res.overflow_count = ovf_next;
    res.queue_count    = fill_wide[4:0];
    res.waiting        = wait_flag_next;
  end

endmodule

`default_nettype wire
